/* rtl/core/esu_pkg.sv */
// ----------------------------------------------------------------------------
// Event statistics unit package
// Shared item types, event codes, read selectors and status codes.
// ----------------------------------------------------------------------------
package esu_pkg;

  localparam int unsigned PROFILE_SLOTS_DEF = 16;
  localparam int unsigned IRQ_LINES_DEF     = 32;

  // Event codes
  localparam logic [3:0] OP_START   = 4'd0;
  localparam logic [3:0] OP_STOP    = 4'd1;
  localparam logic [3:0] OP_RESET   = 4'd2;
  localparam logic [3:0] OP_TICK    = 4'd3;
  localparam logic [3:0] OP_ENTER   = 4'd4;
  localparam logic [3:0] OP_EXIT    = 4'd5;
  localparam logic [3:0] OP_SYSCALL = 4'd6;
  localparam logic [3:0] OP_ALLOC   = 4'd7;
  localparam logic [3:0] OP_FREE    = 4'd8;
  localparam logic [3:0] OP_CTXSW   = 4'd9;
  localparam logic [3:0] OP_IRQ     = 4'd10;
  localparam logic [3:0] OP_READ    = 4'd11;

  // Read selectors
  localparam logic [3:0] RD_RUNNING   = 4'd0;
  localparam logic [3:0] RD_ELAPSED   = 4'd1;
  localparam logic [3:0] RD_SWITCHES  = 4'd2;
  localparam logic [3:0] RD_SYSCALLS  = 4'd3;
  localparam logic [3:0] RD_IRQ       = 4'd4;
  localparam logic [3:0] RD_ALLOC_SUM = 4'd5;
  localparam logic [3:0] RD_FREED_SUM = 4'd6;
  localparam logic [3:0] RD_USAGE     = 4'd7;
  localparam logic [3:0] RD_PEAK      = 4'd8;
  localparam logic [3:0] RD_ALLOC_EV  = 4'd9;
  localparam logic [3:0] RD_FREE_EV   = 4'd10;
  localparam logic [3:0] RD_USED      = 4'd11;
  localparam logic [3:0] RD_CALLS     = 4'd12;
  localparam logic [3:0] RD_SUM       = 4'd13;
  localparam logic [3:0] RD_MIN       = 4'd14;
  localparam logic [3:0] RD_MAX       = 4'd15;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [3:0]  operation;
    logic [63:0] timestamp;
    logic [31:0] func_key;
    logic [7:0]  slot_index;
    logic [31:0] byte_size;
    logic [7:0]  irq_line;
    logic [3:0]  read_item;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_found;
    logic [63:0] read_value;
  } out_item_t;

  // Item after classification by the front end
  typedef struct packed {
    in_item_t item;
    logic     op_ok;
    logic     slot_ok;
    logic     line_ok;
  } cmd_t;

  // Per-slot interval statistics
  typedef struct packed {
    logic [31:0] calls;
    logic [63:0] sum;
    logic [63:0] min;
    logic [63:0] max;
  } row_t;

endpackage

/* rtl/core/esu_front.sv */
// ----------------------------------------------------------------------------
// Event statistics unit front end
// Accepts items, classifies their range checks and queues them for the back end.
// ----------------------------------------------------------------------------
module esu_front #(
  parameter int unsigned PROFILE_SLOTS = esu_pkg::PROFILE_SLOTS_DEF,
  parameter int unsigned IRQ_LINES     = esu_pkg::IRQ_LINES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  esu_pkg::in_item_t in_item,
  output logic             q_valid,
  output esu_pkg::cmd_t    q_cmd,
  input  logic             q_pop
);

  esu_pkg::cmd_t  fifo_r [2];
  logic [1:0]     count_r;
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  esu_pkg::cmd_t  cmd_in;
  logic           push;

  always_comb begin
    cmd_in.item    = in_item;
    cmd_in.op_ok   = (in_item.operation <= esu_pkg::OP_READ);
    cmd_in.slot_ok = ({1'b0, in_item.slot_index} < 9'(PROFILE_SLOTS));
    cmd_in.line_ok = ({1'b0, in_item.irq_line} < 9'(IRQ_LINES));
  end

  assign busy    = (count_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 2'd1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* rtl/core/esu_back.sv */
// ----------------------------------------------------------------------------
// Event statistics unit back end
// Executes queued items against the counters, the irq table and the slot table.
// ----------------------------------------------------------------------------
module esu_back #(
  parameter int unsigned PROFILE_SLOTS = esu_pkg::PROFILE_SLOTS_DEF,
  parameter int unsigned IRQ_LINES     = esu_pkg::IRQ_LINES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  esu_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_strobe,
  output esu_pkg::out_item_t out_item
);

  localparam int unsigned SW = (PROFILE_SLOTS > 1) ? $clog2(PROFILE_SLOTS) : 1;
  localparam int unsigned UW = $clog2(PROFILE_SLOTS + 1);
  localparam int unsigned IW = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SRD, S_CMP, S_EXE, S_EXIT2, S_PEAK
  } state_t;

  state_t                  state_r;
  esu_pkg::cmd_t           cmd_r;
  logic [SW-1:0]           idx_r;
  logic [63:0]             span_r;
  logic                    running_r;
  logic [63:0]             start_time_r;
  logic [63:0]             elapsed_r;
  logic [31:0]             switch_r;
  logic [31:0]             syscall_r;
  logic [63:0]             alloc_sum_r;
  logic [63:0]             freed_sum_r;
  logic [63:0]             usage_r;
  logic [63:0]             peak_r;
  logic [31:0]             alloc_ev_r;
  logic [31:0]             free_ev_r;
  logic [UW-1:0]           used_r;
  logic [PROFILE_SLOTS-1:0] active_r;
  logic [PROFILE_SLOTS-1:0] row_vld_r;
  logic [IRQ_LINES-1:0]    irq_vld_r;
  logic                    out_strobe_r;
  esu_pkg::out_item_t      out_item_r;

  // Memories and their registered read data
  logic [31:0]      key_mem   [PROFILE_SLOTS];
  logic [63:0]      entry_mem [PROFILE_SLOTS];
  esu_pkg::row_t    row_mem   [PROFILE_SLOTS];
  logic [31:0]      irq_mem   [IRQ_LINES];
  logic [31:0]      key_rd_r;
  logic [63:0]      entry_rd_r;
  esu_pkg::row_t    row_rd_r;
  logic             row_v_rd_r;
  logic [31:0]      irq_rd_r;
  logic             irq_v_rd_r;

  logic [SW-1:0]    slot_addr;
  logic [SW-1:0]    new_slot;
  logic [IW-1:0]    irq_addr;
  logic [3:0]       op;
  esu_pkg::row_t    row_q;
  esu_pkg::row_t    row_new;
  logic [31:0]      irq_q;
  logic             hit_now;
  logic             miss_now;
  logic             alloc_now;
  logic             table_full;
  logic             clr_now;
  logic             irq_we;
  logic             row_we;
  logic             entry_we;
  logic [SW-1:0]    entry_addr;
  logic [1:0]       rd_status;
  logic [63:0]      rd_value;
  logic [64:0]      free_diff;

  assign op         = cmd_r.item.operation;
  assign slot_addr  = cmd_r.item.slot_index[SW-1:0];
  assign irq_addr   = cmd_r.item.irq_line[IW-1:0];
  assign new_slot   = SW'(used_r);
  assign table_full = (used_r == UW'(PROFILE_SLOTS));
  assign q_pop      = (state_r == S_IDLE) && q_valid;

  always_comb begin
    if (row_v_rd_r) begin
      row_q = row_rd_r;
    end else begin
      row_q.calls = '0;
      row_q.sum   = '0;
      row_q.min   = '1;
      row_q.max   = '0;
    end
    irq_q = irq_v_rd_r ? irq_rd_r : 32'd0;
  end

  // Enter handling: a hit during the search, or a miss once the last used slot is checked or on an empty table
  always_comb begin
    hit_now  = (state_r == S_CMP) && (key_rd_r == cmd_r.item.func_key);
    miss_now = ((state_r == S_CMP) && !hit_now && (UW'(idx_r) + UW'(1) == used_r)) ||
               ((state_r == S_EXE) && (op == esu_pkg::OP_ENTER) && running_r);
    alloc_now  = miss_now && !table_full;
    entry_we   = alloc_now || hit_now;
    entry_addr = alloc_now ? new_slot : idx_r;
    clr_now    = (state_r == S_EXE) &&
                 ((op == esu_pkg::OP_RESET) || ((op == esu_pkg::OP_START) && !running_r));
    irq_we     = (state_r == S_EXE) && (op == esu_pkg::OP_IRQ) && running_r && cmd_r.line_ok;
    row_we     = (state_r == S_EXIT2);
    free_diff  = {1'b0, usage_r} - {33'd0, cmd_r.item.byte_size};
  end

  always_comb begin
    row_new.calls = row_q.calls + 32'd1;
    row_new.sum   = row_q.sum + span_r;
    row_new.min   = (span_r < row_q.min) ? span_r : row_q.min;
    row_new.max   = (span_r > row_q.max) ? span_r : row_q.max;
  end

  always_comb begin
    rd_status = esu_pkg::ST_DONE;
    rd_value  = 64'd0;
    if ((cmd_r.item.read_item >= esu_pkg::RD_CALLS) &&
        !({1'b0, cmd_r.item.slot_index} < 9'(used_r))) begin
      rd_status = esu_pkg::ST_IGNORED;
    end else begin
      unique case (cmd_r.item.read_item)
        esu_pkg::RD_RUNNING:   rd_value = {63'd0, running_r};
        esu_pkg::RD_ELAPSED:   rd_value = elapsed_r;
        esu_pkg::RD_SWITCHES:  rd_value = {32'd0, switch_r};
        esu_pkg::RD_SYSCALLS:  rd_value = {32'd0, syscall_r};
        esu_pkg::RD_IRQ: begin
          if (cmd_r.line_ok) begin
            rd_value = {32'd0, irq_q};
          end else begin
            rd_status = esu_pkg::ST_IGNORED;
          end
        end
        esu_pkg::RD_ALLOC_SUM: rd_value = alloc_sum_r;
        esu_pkg::RD_FREED_SUM: rd_value = freed_sum_r;
        esu_pkg::RD_USAGE:     rd_value = usage_r;
        esu_pkg::RD_PEAK:      rd_value = peak_r;
        esu_pkg::RD_ALLOC_EV:  rd_value = {32'd0, alloc_ev_r};
        esu_pkg::RD_FREE_EV:   rd_value = {32'd0, free_ev_r};
        esu_pkg::RD_USED:      rd_value = 64'(used_r);
        esu_pkg::RD_CALLS:     rd_value = {32'd0, row_q.calls};
        esu_pkg::RD_SUM:       rd_value = row_q.sum;
        esu_pkg::RD_MIN:       rd_value = row_q.min;
        default:               rd_value = row_q.max;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      running_r    <= 1'b0;
      start_time_r <= '0;
      elapsed_r    <= '0;
      switch_r     <= '0;
      syscall_r    <= '0;
      alloc_sum_r  <= '0;
      freed_sum_r  <= '0;
      usage_r      <= '0;
      peak_r       <= '0;
      alloc_ev_r   <= '0;
      free_ev_r    <= '0;
      used_r       <= '0;
      active_r     <= '0;
      row_vld_r    <= '0;
      irq_vld_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_cmd;
            idx_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          if ((op == esu_pkg::OP_ENTER) && running_r && (used_r != '0)) begin
            state_r <= S_CMP;
          end else begin
            state_r <= S_EXE;
          end
        end
        S_SRD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (hit_now || miss_now) begin
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + SW'(1);
            state_r <= S_SRD;
          end
        end
        S_EXE: begin
          state_r <= S_IDLE;
          if (op == esu_pkg::OP_RESET) begin
            out_strobe_r <= 1'b1;
            out_item_r   <= '{esu_pkg::ST_DONE, 8'd0, 64'd0};
          end else if (op == esu_pkg::OP_READ) begin
            out_strobe_r <= 1'b1;
            out_item_r   <= '{rd_status, 8'd0, rd_value};
          end else if (op == esu_pkg::OP_START) begin
            out_strobe_r <= 1'b1;
            if (running_r) begin
              out_item_r <= '{esu_pkg::ST_IGNORED, 8'd0, 64'd0};
            end else begin
              start_time_r <= cmd_r.item.timestamp;
              running_r    <= 1'b1;
              out_item_r   <= '{esu_pkg::ST_DONE, 8'd0, 64'd0};
            end
          end else if (!cmd_r.op_ok || !running_r) begin
            out_strobe_r <= 1'b1;
            out_item_r   <= '{esu_pkg::ST_IGNORED, 8'd0, 64'd0};
          end else begin
            out_strobe_r <= 1'b1;
            out_item_r   <= '{esu_pkg::ST_DONE, 8'd0, 64'd0};
            case (op)
              esu_pkg::OP_STOP: begin
                elapsed_r <= cmd_r.item.timestamp - start_time_r;
                running_r <= 1'b0;
              end
              esu_pkg::OP_TICK: begin
                elapsed_r <= cmd_r.item.timestamp - start_time_r;
              end
              esu_pkg::OP_EXIT: begin
                if (!cmd_r.slot_ok || !active_r[slot_addr]) begin
                  out_item_r <= '{esu_pkg::ST_IGNORED, 8'd0, 64'd0};
                end else begin
                  // The result goes out once the statistics row is written back.
                  out_strobe_r       <= 1'b0;
                  span_r             <= cmd_r.item.timestamp - entry_rd_r;
                  active_r[slot_addr] <= 1'b0;
                  state_r            <= S_EXIT2;
                end
              end
              esu_pkg::OP_SYSCALL: syscall_r <= syscall_r + 32'd1;
              esu_pkg::OP_ALLOC: begin
                alloc_sum_r <= alloc_sum_r + 64'(cmd_r.item.byte_size);
                usage_r     <= usage_r + 64'(cmd_r.item.byte_size);
                alloc_ev_r  <= alloc_ev_r + 32'd1;
                state_r     <= S_PEAK;
              end
              esu_pkg::OP_FREE: begin
                freed_sum_r <= freed_sum_r + 64'(cmd_r.item.byte_size);
                free_ev_r   <= free_ev_r + 32'd1;
                usage_r     <= free_diff[64] ? 64'd0 : free_diff[63:0];
              end
              esu_pkg::OP_CTXSW: switch_r <= switch_r + 32'd1;
              esu_pkg::OP_IRQ: begin
                if (cmd_r.line_ok) begin
                  irq_vld_r[irq_addr] <= 1'b1;
                end else begin
                  out_item_r <= '{esu_pkg::ST_IGNORED, 8'd0, 64'd0};
                end
              end
              default: ;
            endcase
          end
        end
        S_EXIT2: begin
          row_vld_r[slot_addr] <= 1'b1;
          out_strobe_r         <= 1'b1;
          out_item_r           <= '{esu_pkg::ST_DONE, 8'd0, 64'd0};
          state_r              <= S_IDLE;
        end
        S_PEAK: begin
          if (usage_r > peak_r) begin
            peak_r <= usage_r;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      // Enter outcome, shared by the search and the empty-table case
      if (hit_now) begin
        active_r[idx_r] <= 1'b1;
        out_strobe_r    <= 1'b1;
        out_item_r      <= '{esu_pkg::ST_DONE, 8'(idx_r), 64'd0};
      end else if (alloc_now) begin
        active_r[new_slot]  <= 1'b1;
        row_vld_r[new_slot] <= 1'b0;
        used_r              <= used_r + UW'(1);
        out_strobe_r        <= 1'b1;
        out_item_r          <= '{esu_pkg::ST_DONE, 8'(new_slot), 64'd0};
      end else if (miss_now) begin
        out_strobe_r <= 1'b1;
        out_item_r   <= '{esu_pkg::ST_FULL, 8'd0, 64'd0};
      end

      // A cleared entry reads back as its reset value through the valid bits.
      if (clr_now) begin
        elapsed_r   <= '0;
        switch_r    <= '0;
        syscall_r   <= '0;
        alloc_sum_r <= '0;
        freed_sum_r <= '0;
        usage_r     <= '0;
        peak_r      <= '0;
        alloc_ev_r  <= '0;
        free_ev_r   <= '0;
        active_r    <= '0;
        row_vld_r   <= '0;
        irq_vld_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_now) begin
      key_mem[new_slot] <= cmd_r.item.func_key;
    end
    if (entry_we) begin
      entry_mem[entry_addr] <= cmd_r.item.timestamp;
    end
    if (row_we) begin
      row_mem[slot_addr] <= row_new;
    end
    if (irq_we) begin
      irq_mem[irq_addr] <= irq_q + 32'd1;
    end
    key_rd_r   <= key_mem[idx_r];
    entry_rd_r <= entry_mem[slot_addr];
    row_rd_r   <= row_mem[slot_addr];
    row_v_rd_r <= row_vld_r[slot_addr];
    irq_rd_r   <= irq_mem[irq_addr];
    irq_v_rd_r <= irq_vld_r[irq_addr];
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

/* rtl/core/event_statistics_unit.sv */
// ----------------------------------------------------------------------------
// Event statistics unit
// Counts time-stamped system events and keeps per-function interval profiles.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result, shown for one cycle on
// out_strobe; results cannot be held off, so they must be taken as they come.
// A two-entry queue takes items while busy is low. The back end executes one
// item at a time: most items pass through S_RD and S_EXE after they leave
// the queue. An alloc then holds the back end in S_PEAK to update the peak
// usage, and an exit that closes an active slot gives its result from S_EXIT2,
// after the read-modify-write of the slot statistics row. An enter while
// running compares one stored key from the key memory at a time in S_CMP,
// reading the next through S_SRD until a hit or the last used slot is checked;
// on an empty table it goes through S_EXE. Results come out in item order.
module event_statistics_unit #(
  parameter int unsigned PROFILE_SLOTS = esu_pkg::PROFILE_SLOTS_DEF,
  parameter int unsigned IRQ_LINES     = esu_pkg::IRQ_LINES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  esu_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output esu_pkg::out_item_t out_item
);

  logic          q_valid;
  logic          q_pop;
  esu_pkg::cmd_t q_cmd;

  esu_front #(
    .PROFILE_SLOTS(PROFILE_SLOTS),
    .IRQ_LINES    (IRQ_LINES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_item(in_item),
    .q_valid(q_valid),
    .q_cmd  (q_cmd),
    .q_pop  (q_pop)
  );

  esu_back #(
    .PROFILE_SLOTS(PROFILE_SLOTS),
    .IRQ_LINES    (IRQ_LINES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

endmodule
